// ===== hdl/irpd_pkg.sv =====
// Shared types and constants for the IR packet deframer.
`default_nettype none

package irpd_pkg;

    localparam int DATA_BITS       = 24;
    localparam int CRC_BITS        = 5;
    localparam int BODY_BITS       = DATA_BITS + CRC_BITS;
    localparam int BODY_CNT_W      = $clog2(BODY_BITS + 1);
    localparam int CRC_STEP_W      = $clog2(DATA_BITS);
    localparam int RUN_W           = 4;
    localparam int RUN_MAX         = 15;
    localparam int INDEX_W         = 8;
    localparam int BYTE_W          = 8;
    localparam int COUNT_W         = 9;
    localparam int QUEUE_DEPTH     = 2;
    localparam int MAX_PACKETS_DEF = 256;
    localparam int HEADER_RUN_DEF  = 10;

    localparam logic [DATA_BITS-1:0] CRC_POLY_RESET = 24'h280000;

    typedef struct packed {
        logic [DATA_BITS-1:0] data;
        logic [CRC_BITS-1:0]  crc;
    } packet_t;

    typedef struct packed {
        logic               crc_ok;
        logic [INDEX_W-1:0] packet_index;
        logic [BYTE_W-1:0]  first_byte;
        logic [BYTE_W-1:0]  second_byte;
        logic               length_known;
        logic [COUNT_W-1:0] message_packets;
        logic               message_done;
    } result_t;

    typedef enum logic [1:0] {
        PH_HUNT = 2'b01,
        PH_BODY = 2'b10
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_CRC  = 3'b010,
        BK_BOOK = 3'b100
    } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/irpd_fifo.sv =====
// Small two-entry queue used between the deframer stages and at the result side.
`default_nettype none

module irpd_fifo #(
    parameter int WIDTH = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  full,
    output logic                  empty
);

    localparam int DEPTH = irpd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/irpd_front.sv =====
// Front stage: header hunt and packet bit collection.
`default_nettype none

module irpd_front #(
    parameter int HEADER_RUN = irpd_pkg::HEADER_RUN_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              ir_bit,
    output logic                   pkt_push,
    output irpd_pkg::packet_t      pkt_data
);

    localparam int RUN_W = irpd_pkg::RUN_W;
    localparam int CNT_W = irpd_pkg::BODY_CNT_W;
    localparam int BODY  = irpd_pkg::BODY_BITS;

    localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(irpd_pkg::RUN_MAX);
    localparam logic [RUN_W-1:0] HDR_LEN   = RUN_W'(HEADER_RUN);

    irpd_pkg::front_state_t state_reg, state_next;
    logic [RUN_W-1:0]       zero_run_reg, zero_run_next;
    logic [RUN_W-1:0]       one_run_reg, one_run_next;
    logic                   zero_seen_reg, zero_seen_next;
    logic                   prev_bit_reg, prev_bit_next;
    logic [CNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [BODY-1:0]        shift_reg, shift_next;
    logic                   last_bit;

    assign last_bit = (bit_cnt_reg == CNT_W'(BODY - 1));
    assign shift_next = {shift_reg[BODY-2:0], ir_bit};
    assign pkt_push = accept && (state_reg == irpd_pkg::PH_BODY) && last_bit;
    assign pkt_data = irpd_pkg::packet_t'(shift_next);

    always_comb
    begin
        state_next     = state_reg;
        zero_run_next  = zero_run_reg;
        one_run_next   = one_run_reg;
        zero_seen_next = zero_seen_reg;
        prev_bit_next  = prev_bit_reg;
        bit_cnt_next   = bit_cnt_reg;
        if (accept)
        begin
            unique case (state_reg)
                irpd_pkg::PH_HUNT:
                begin
                    prev_bit_next = ir_bit;
                    if (!ir_bit)
                    begin
                        if (!prev_bit_reg)
                        begin
                            if (zero_run_reg < RUN_LIMIT)
                            begin
                                zero_run_next = zero_run_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            zero_run_next  = RUN_W'(1);
                            zero_seen_next = 1'b0;
                        end
                        if (zero_run_next >= HDR_LEN)
                        begin
                            zero_seen_next = 1'b1;
                        end
                    end
                    else if (zero_seen_reg)
                    begin
                        if (!prev_bit_reg)
                        begin
                            one_run_next = RUN_W'(1);
                        end
                        else if (one_run_reg < RUN_LIMIT)
                        begin
                            one_run_next = one_run_reg + 1'b1;
                        end
                        if (one_run_next == HDR_LEN)
                        begin
                            state_next     = irpd_pkg::PH_BODY;
                            bit_cnt_next   = '0;
                            zero_seen_next = 1'b0;
                            one_run_next   = '0;
                        end
                    end
                end
                irpd_pkg::PH_BODY:
                begin
                    if (last_bit)
                    begin
                        state_next   = irpd_pkg::PH_HUNT;
                        bit_cnt_next = '0;
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_next = irpd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= irpd_pkg::PH_HUNT;
            zero_run_reg  <= '0;
            one_run_reg   <= '0;
            zero_seen_reg <= 1'b0;
            prev_bit_reg  <= 1'b1;
            bit_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            zero_run_reg  <= zero_run_next;
            one_run_reg   <= one_run_next;
            zero_seen_reg <= zero_seen_next;
            prev_bit_reg  <= prev_bit_next;
            bit_cnt_reg   <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (state_reg == irpd_pkg::PH_BODY))
        begin
            shift_reg <= shift_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/irpd_back.sv =====
// Back stage: serial CRC check and message bookkeeping per packet.
`default_nettype none

module irpd_back #(
    parameter int MAX_PACKETS = irpd_pkg::MAX_PACKETS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [irpd_pkg::DATA_BITS-1:0]      cfg_data,
    input  wire logic                                pkt_empty,
    input  wire irpd_pkg::packet_t                   pkt_data,
    output logic                                     pkt_pop,
    input  wire logic                                res_full,
    output logic                                     res_push,
    output irpd_pkg::result_t                        res_data
);

    localparam int DW      = irpd_pkg::DATA_BITS;
    localparam int CW      = irpd_pkg::CRC_BITS;
    localparam int STEP_W  = irpd_pkg::CRC_STEP_W;
    localparam int IDX_W   = irpd_pkg::INDEX_W;
    localparam int CNT_W   = irpd_pkg::COUNT_W;
    localparam int BW      = irpd_pkg::BYTE_W;
    localparam int MAP_W   = $clog2(MAX_PACKETS);
    localparam int MAP_N   = 2 ** MAP_W;

    localparam logic [CNT_W-1:0] MAX_P = CNT_W'(MAX_PACKETS);

    irpd_pkg::back_state_t  state_reg, state_next;
    logic [DW-1:0]          poly_reg;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    irpd_pkg::packet_t      pkt_reg;
    logic [MAP_N-1:0]       seen_reg;
    logic [CNT_W-1:0]       distinct_reg, distinct_next;
    logic [IDX_W-1:0]       last_idx_reg, last_idx_next;
    logic                   last_valid_reg, last_valid_next;
    logic [CNT_W-1:0]       length_reg, length_next;
    logic                   length_valid_reg, length_valid_next;
    logic                   done_reg, done_next;
    logic                   load;
    logic                   book;
    logic                   crc_ok;
    logic [IDX_W-1:0]       idx;
    logic                   record;
    logic                   was_seen;

    assign idx      = pkt_reg.data[DW-1 -: IDX_W];
    assign crc_ok   = (pkt_reg.crc == rem_reg[DW-1 -: CW]);
    assign record   = crc_ok && ({1'b0, idx} < MAX_P);
    assign was_seen = seen_reg[idx[MAP_W-1:0]];
    assign load     = (state_reg == irpd_pkg::BK_IDLE) && !pkt_empty;
    assign pkt_pop  = load;
    assign book     = (state_reg == irpd_pkg::BK_BOOK) && !res_full;
    assign res_push = book;

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        unique case (state_reg)
            irpd_pkg::BK_IDLE:
            begin
                rem_next  = pkt_data.data;
                step_next = '0;
                if (load && !done_reg)
                begin
                    state_next = irpd_pkg::BK_CRC;
                end
            end
            irpd_pkg::BK_CRC:
            begin
                rem_next  = {rem_reg[DW-2:0] ^ (rem_reg[DW-1] ? poly_reg[DW-2:0] : '0), 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DW - 1))
                begin
                    state_next = irpd_pkg::BK_BOOK;
                end
            end
            irpd_pkg::BK_BOOK:
            begin
                if (book)
                begin
                    state_next = irpd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = irpd_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        distinct_next     = distinct_reg;
        last_idx_next     = last_idx_reg;
        last_valid_next   = last_valid_reg;
        length_next       = length_reg;
        length_valid_next = length_valid_reg;
        if (record)
        begin
            if (!was_seen)
            begin
                distinct_next = distinct_reg + 1'b1;
            end
            if (!length_valid_reg)
            begin
                if (last_valid_reg && (idx <= last_idx_reg))
                begin
                    length_next       = {1'b0, last_idx_reg} + 1'b1;
                    length_valid_next = 1'b1;
                end
                else
                begin
                    last_idx_next   = idx;
                    last_valid_next = 1'b1;
                end
            end
        end
        done_next = length_valid_next && (distinct_next >= length_next);
    end

    always_comb
    begin
        res_data.crc_ok          = crc_ok;
        res_data.packet_index    = idx;
        res_data.first_byte      = pkt_reg.data[BW +: BW];
        res_data.second_byte     = pkt_reg.data[BW-1:0];
        res_data.length_known    = length_valid_next;
        res_data.message_packets = length_valid_next ? length_next : '0;
        res_data.message_done    = done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= irpd_pkg::BK_IDLE;
            poly_reg         <= irpd_pkg::CRC_POLY_RESET;
            seen_reg         <= '0;
            distinct_reg     <= '0;
            last_idx_reg     <= '0;
            last_valid_reg   <= 1'b0;
            length_reg       <= '0;
            length_valid_reg <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                poly_reg <= cfg_data;
            end
            if (book)
            begin
                if (record)
                begin
                    seen_reg[idx[MAP_W-1:0]] <= 1'b1;
                end
                distinct_reg     <= distinct_next;
                last_idx_reg     <= last_idx_next;
                last_valid_reg   <= last_valid_next;
                length_reg       <= length_next;
                length_valid_reg <= length_valid_next;
                done_reg         <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        step_reg <= step_next;
        if (load)
        begin
            pkt_reg <= pkt_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ir_packet_deframer_core.sv =====
// Top level of the IR packet deframer: front stage, packet queue, back stage, result queue.
//
// Input side: one sampled IR bit per transaction on ir_bit, taken when push is
// high and full is low. While full is low, bits stream in one per cycle with no gaps needed.
// A front stage hunts for the header (long zero run, then the set count of ones)
// and gathers the 29 packet bits; each finished packet enters a two-entry queue.
// The back stage takes one packet, runs the CRC one division step per cycle,
// then updates the seen-index map and message length and writes the result
// into a two-entry result queue. Packets are at least 49 bits apart, so the
// back stage keeps up and full stays low unless results are left unpopped.
// Result side: the oldest result is shown while empty is low; pop takes it.
// When the receiver stalls, results collect in the queues and full rises once
// two finished packets wait; input resumes once pop frees space and the back stage takes the next packet.
// Once the message is complete, further bits are taken and dropped.
// Reset clears all hunt state, bookkeeping and queues and loads the default
// CRC polynomial; cfg_ready is always high and a write replaces the polynomial.
`default_nettype none

module ir_packet_deframer_core #(
    parameter int MAX_PACKETS = irpd_pkg::MAX_PACKETS_DEF,
    parameter int HEADER_RUN  = irpd_pkg::HEADER_RUN_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic                               ir_bit,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic                                    crc_ok,
    output logic [irpd_pkg::INDEX_W-1:0]            packet_index,
    output logic [irpd_pkg::BYTE_W-1:0]             first_byte,
    output logic [irpd_pkg::BYTE_W-1:0]             second_byte,
    output logic                                    length_known,
    output logic [irpd_pkg::COUNT_W-1:0]            message_packets,
    output logic                                    message_done,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [irpd_pkg::DATA_BITS-1:0]     cfg_data
);

    localparam int PKT_W = $bits(irpd_pkg::packet_t);
    localparam int RES_W = $bits(irpd_pkg::result_t);

    logic              accept;
    logic              front_push;
    irpd_pkg::packet_t front_pkt;
    logic [PKT_W-1:0]  queue_rdata;
    logic              queue_empty;
    logic              queue_pop;
    logic              res_full;
    logic              res_push;
    irpd_pkg::result_t res_wdata;
    logic [RES_W-1:0]  res_rdata;
    irpd_pkg::result_t res_head;

    assign accept    = push && !full;
    assign cfg_ready = 1'b1;

    irpd_front #(
        .HEADER_RUN (HEADER_RUN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .ir_bit   (ir_bit),
        .pkt_push (front_push),
        .pkt_data (front_pkt)
    );

    irpd_fifo #(
        .WIDTH (PKT_W)
    ) u_pkt_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (PKT_W'(front_pkt)),
        .pop   (queue_pop),
        .rdata (queue_rdata),
        .full  (full),
        .empty (queue_empty)
    );

    irpd_back #(
        .MAX_PACKETS (MAX_PACKETS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .pkt_empty (queue_empty),
        .pkt_data  (irpd_pkg::packet_t'(queue_rdata)),
        .pkt_pop   (queue_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_wdata)
    );

    irpd_fifo #(
        .WIDTH (RES_W)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (RES_W'(res_wdata)),
        .pop   (pop),
        .rdata (res_rdata),
        .full  (res_full),
        .empty (empty)
    );

    assign res_head        = irpd_pkg::result_t'(res_rdata);
    assign crc_ok          = res_head.crc_ok;
    assign packet_index    = res_head.packet_index;
    assign first_byte      = res_head.first_byte;
    assign second_byte     = res_head.second_byte;
    assign length_known    = res_head.length_known;
    assign message_packets = res_head.message_packets;
    assign message_done    = res_head.message_done;

endmodule

`default_nettype wire
